// ===== rtl/mbd_pkg.sv =====
// ----------------------------------------------------------------------------
// Multi-button debouncer package
// Beat types, register indexes and the per-button status shared by the lanes.
// ----------------------------------------------------------------------------
package mbd_pkg;

  localparam int MAX_BUTTONS = 8;
  localparam int BTN_IDX_W   = 3;
  localparam int COUNT_W     = 8;
  localparam int INTERVAL_W  = 16;
  localparam int TIME_W      = 32;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_INTERVAL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_REQUIRED_COUNT  = 1'b1;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd20;
  localparam logic [COUNT_W-1:0]    REQUIRED_RESET = 8'd5;
  localparam logic [COUNT_W-1:0]    COUNT_MAX      = 8'hFF;

  typedef struct packed {
    logic [TIME_W-1:0]      now_ms;
    logic [MAX_BUTTONS-1:0] button_bits;
    logic                   take_event;
    logic                   clear_request;
    logic [BTN_IDX_W-1:0]   clear_button;
  } mbd_in_t;

  typedef struct packed {
    logic                   sampled;
    logic                   event_valid;
    logic [BTN_IDX_W-1:0]   event_button;
    logic                   event_pressed;
    logic [MAX_BUTTONS-1:0] stable_levels;
  } mbd_out_t;

  typedef struct packed {
    logic flip;
    logic new_level;
    logic level_nxt;
  } lane_stat_t;

endpackage

// ===== rtl/mbd_lane.sv =====
// ----------------------------------------------------------------------------
// Debounce lane
// Holds one button's stable level and count of differing samples.
// ----------------------------------------------------------------------------
module mbd_lane
  import mbd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               sample_en,
  input  logic               raw_bit,
  input  logic               clear_en,
  input  logic [COUNT_W-1:0] required_count,
  output lane_stat_t         stat
);

  logic               level_r;
  logic               level_nxt;
  logic [COUNT_W-1:0] cnt_r;
  logic [COUNT_W-1:0] cnt_nxt;
  logic [COUNT_W-1:0] cnt_inc;
  logic               differ;
  logic               flip;

  always_comb begin
    differ    = raw_bit != level_r;
    cnt_inc   = (cnt_r == COUNT_MAX) ? cnt_r : cnt_r + COUNT_W'(1);
    flip      = sample_en && differ && (cnt_inc >= required_count);
    level_nxt = level_r;
    cnt_nxt   = cnt_r;
    if (sample_en) begin
      if (!differ) begin
        cnt_nxt = '0;
      end else if (flip) begin
        level_nxt = raw_bit;
        cnt_nxt   = '0;
      end else begin
        cnt_nxt = cnt_inc;
      end
    end
    if (clear_en) begin
      level_nxt = 1'b0;
      cnt_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      level_r <= level_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign stat.flip      = flip;
  assign stat.new_level = raw_bit;
  assign stat.level_nxt = level_nxt;

endmodule

// ===== rtl/mbd_merge.sv =====
// ----------------------------------------------------------------------------
// Debounce event merge
// Picks the lowest button that changed level, keeps the pending event and
// builds the result beat.
// ----------------------------------------------------------------------------
module mbd_merge
  import mbd_pkg::*;
#(
  parameter int NUM_BUTTONS = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic                         sampled,
  input  logic                         take_event,
  input  lane_stat_t [NUM_BUTTONS-1:0] lane_stat,
  output mbd_out_t                     result
);

  logic                 pending_r;
  logic                 pending_nxt;
  logic [BTN_IDX_W-1:0] button_r;
  logic [BTN_IDX_W-1:0] button_nxt;
  logic                 pressed_r;
  logic                 pressed_nxt;
  logic                 any_flip;
  logic [BTN_IDX_W-1:0] sel_button;
  logic                 sel_pressed;
  logic                 pend_s;
  logic                 ev_valid;

  always_comb begin
    any_flip    = 1'b0;
    sel_button  = '0;
    sel_pressed = 1'b0;
    for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
      if (lane_stat[i].flip) begin
        any_flip    = 1'b1;
        sel_button  = BTN_IDX_W'(i);
        sel_pressed = lane_stat[i].new_level;
      end
    end

    pend_s      = pending_r;
    button_nxt  = button_r;
    pressed_nxt = pressed_r;
    if (!pending_r && any_flip) begin
      pend_s      = 1'b1;
      button_nxt  = sel_button;
      pressed_nxt = sel_pressed;
    end

    ev_valid    = take_event && pend_s;
    pending_nxt = pend_s && !ev_valid;

    result               = '0;
    result.sampled       = sampled;
    result.event_valid   = ev_valid;
    result.event_button  = ev_valid ? button_nxt : '0;
    result.event_pressed = ev_valid && pressed_nxt;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      result.stable_levels[i] = lane_stat[i].level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
      button_r  <= '0;
      pressed_r <= 1'b0;
    end else if (accept) begin
      pending_r <= pending_nxt;
      button_r  <= button_nxt;
      pressed_r <= pressed_nxt;
    end
  end

endmodule

// ===== rtl/multi_button_debouncer.sv =====
// ----------------------------------------------------------------------------
// Multi-button debouncer
// Polls a bank of buttons in parallel lanes and reports debounced levels and
// press or release events.
//
//   Channel | Ports                        | Beat
//   --------+------------------------------+-------------------------------
//   input   | in_valid, in_stall, in_data  | time, raw bits, take, clear
//   output  | out_valid, out_stall, out_data | sampled, event, levels
//   config  | cfg_we, cfg_index, cfg_wdata | interval (0), required count (1)
//
// One input beat is taken each cycle while in_stall is low; all lanes and
// the interval compare are combinational and the beat's result is registered.
// Synchronous reset clears levels, counts, last sample time and the event.
// An output register and a skid register keep input flowing for one beat
// while the output is stalled; in_stall rises only when both are full.
// ----------------------------------------------------------------------------
module multi_button_debouncer
  import mbd_pkg::*;
#(
  parameter int NUM_BUTTONS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  mbd_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output mbd_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [INTERVAL_W-1:0] interval_r;
  logic [COUNT_W-1:0]    required_r;
  logic [TIME_W-1:0]     last_time_r;
  logic [TIME_W-1:0]     elapsed;
  logic                  accept;
  logic                  do_sample;
  logic                  sample_en;
  mbd_out_t              result;
  mbd_out_t              out_data_r;
  mbd_out_t              skid_data_r;
  logic                  out_valid_r;
  logic                  skid_valid_r;
  logic                  pop;

  lane_stat_t [NUM_BUTTONS-1:0] lane_stat;

  assign accept    = in_valid && !in_stall;
  assign elapsed   = in_data.now_ms - last_time_r;
  assign do_sample = elapsed >= TIME_W'(interval_r);
  assign sample_en = accept && do_sample;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= INTERVAL_RESET;
      required_r <= REQUIRED_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SAMPLE_INTERVAL: interval_r <= cfg_wdata;
        REG_REQUIRED_COUNT:  required_r <= cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_time_r <= '0;
    end else if (sample_en) begin
      last_time_r <= in_data.now_ms;
    end
  end

  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
    mbd_lane u_lane (
      .clk            (clk),
      .rst_n          (rst_n),
      .sample_en      (sample_en),
      .raw_bit        (in_data.button_bits[b]),
      .clear_en       (accept && in_data.clear_request
                       && (in_data.clear_button == BTN_IDX_W'(b))),
      .required_count (required_r),
      .stat           (lane_stat[b])
    );
  end

  mbd_merge #(
    .NUM_BUTTONS (NUM_BUTTONS)
  ) u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .sampled    (do_sample),
    .take_event (in_data.take_event),
    .lane_stat  (lane_stat),
    .result     (result)
  );

  assign pop      = out_valid_r && !out_stall;
  assign in_stall = skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop) begin
      if (skid_valid_r) begin
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= accept;
      end
    end else if (accept) begin
      if (!out_valid_r) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (accept) begin
        out_data_r <= result;
      end
    end else if (accept) begin
      if (!out_valid_r) begin
        out_data_r <= result;
      end else begin
        skid_data_r <= result;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/mbd_checker.sv =====
// ----------------------------------------------------------------------------
// Multi-button debouncer checker
// Watches the top-level ports of the debouncer over time.
// ----------------------------------------------------------------------------
module mbd_checker
  import mbd_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input mbd_out_t out_data
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output beat present straight after reset");

  a_accept_yields_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted input beat produced no output beat");

  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled while the output is empty");

  a_no_event_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.event_valid |->
      out_data.event_button == '0 && !out_data.event_pressed)
    else $error("event fields set without an event");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

endmodule

bind multi_button_debouncer mbd_checker u_mbd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
